### sv/clipped_bresenham_line_plotter_assert.svh
// Assertion macros shared by the line plotter RTL.
`ifndef CLIPPED_BRESENHAM_LINE_PLOTTER_ASSERT_SVH
`define CLIPPED_BRESENHAM_LINE_PLOTTER_ASSERT_SVH

// Checked on every rising edge of clk, ignored while reset is asserted.
`define CBLP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked on every rising edge of clk, reset included.
`define CBLP_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/clbp_pkg.sv
// Types, codes and constants shared by the line plotter modules.
package clbp_pkg;

	localparam int COORD_BITS_DEF = 16;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 18;

	localparam logic [2:0] BYTES_THREE = 3'd3;
	localparam logic [2:0] BYTES_FOUR = 3'd4;

	typedef enum logic {
		OP_START = 1'b0,
		OP_ADVANCE = 1'b1
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SCREEN_WIDTH = 3'd0,
		REG_SCREEN_HEIGHT = 3'd1,
		REG_ROW_PITCH = 3'd2,
		REG_THREE_BYTE = 3'd3,
		REG_BGR_ORDER = 3'd4,
		REG_BUFFER_READY = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic [14:0] screen_width;
		logic [14:0] screen_height;
		logic [17:0] row_pitch_bytes;
		logic three_byte_pixels;
		logic bgr_order;
		logic buffer_ready;
	} cfg_t;

	typedef struct packed {
		logic idle;
		logic done;
	} pix_flags_t;

endpackage

### sv/clipped_bresenham_line_plotter.sv
// Clipped Bresenham line plotter top level with handshake and configuration registers.
//
// Input channel: in_valid/in_stall carry one command per transfer. opcode start
// loads the endpoints and colour and yields the first pixel; opcode advance takes
// one Bresenham step and yields the next pixel, or an idle result with line_done
// set when no line is active. Every command yields exactly one result.
// Output channel: out_valid/out_stall carry one pixel write per transfer.
// Path: an accepted command is registered in the first stage and then in the output
// register, which presents it on out_valid.
// Throughput: one command per cycle while the receiver does not stall; the two-stage
// pipeline keeps accepting while a result waits.
// When the receiver stalls, the output register and then the first stage fill,
// and in_stall rises only once both hold an item.
// Configuration: cfg_valid/cfg_ready write one register per transfer, cfg_ready
// is always high; write only while no command is in flight.
// Reset clears the valid flags, configuration and line state; the block is then idle.
module clipped_bresenham_line_plotter #(
	parameter int COORD_BITS = clbp_pkg::COORD_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic opcode,
	input  logic signed [15:0] start_x,
	input  logic signed [15:0] start_y,
	input  logic signed [15:0] end_x,
	input  logic signed [15:0] end_y,
	input  logic [23:0] color_rgb,
	output logic out_valid,
	input  logic out_stall,
	output logic write_enable,
	output logic signed [15:0] pixel_x,
	output logic signed [15:0] pixel_y,
	output logic [33:0] byte_offset,
	output logic [31:0] pixel_word,
	output logic [2:0] write_bytes,
	output logic line_done,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [clbp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [clbp_pkg::CFG_DATA_W-1:0] cfg_data
);
	import clbp_pkg::*;

	`include "clipped_bresenham_line_plotter_assert.svh"

	cfg_t cfg_q;
	logic valid_s1_q, valid_s2_q;
	logic adv2, load1, load2;
	logic signed [COORD_BITS-1:0] x_s1, y_s1;
	pix_flags_t flags_s1;
	logic [23:0] color_s1;

	assign cfg_ready = 1'b1;
	assign adv2 = !valid_s2_q || !out_stall;
	assign in_stall = valid_s1_q && !adv2;
	assign load1 = in_valid && !in_stall;
	assign load2 = valid_s1_q && adv2;
	assign out_valid = valid_s2_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1_q <= 1'b0;
			valid_s2_q <= 1'b0;
		end else begin
			if (load1) begin
				valid_s1_q <= 1'b1;
			end else if (adv2) begin
				valid_s1_q <= 1'b0;
			end
			if (adv2) begin
				valid_s2_q <= valid_s1_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_SCREEN_WIDTH: cfg_q.screen_width <= cfg_data[14:0];
				REG_SCREEN_HEIGHT: cfg_q.screen_height <= cfg_data[14:0];
				REG_ROW_PITCH: cfg_q.row_pitch_bytes <= cfg_data[17:0];
				REG_THREE_BYTE: cfg_q.three_byte_pixels <= cfg_data[0];
				REG_BGR_ORDER: cfg_q.bgr_order <= cfg_data[0];
				REG_BUFFER_READY: cfg_q.buffer_ready <= cfg_data[0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	clbp_step #(
		.COORD_BITS(COORD_BITS)
	) u_step (
		.clk(clk),
		.arst_n(arst_n),
		.load(load1),
		.opcode(opcode),
		.start_x(start_x),
		.start_y(start_y),
		.end_x(end_x),
		.end_y(end_y),
		.color_rgb(color_rgb),
		.x_s1(x_s1),
		.y_s1(y_s1),
		.flags_s1(flags_s1),
		.color_s1(color_s1)
	);

	clbp_fmt #(
		.COORD_BITS(COORD_BITS)
	) u_fmt (
		.clk(clk),
		.load(load2),
		.x_s1(x_s1),
		.y_s1(y_s1),
		.flags_s1(flags_s1),
		.color_s1(color_s1),
		.cfg(cfg_q),
		.write_enable_s2(write_enable),
		.pixel_x_s2(pixel_x),
		.pixel_y_s2(pixel_y),
		.byte_offset_s2(byte_offset),
		.pixel_word_s2(pixel_word),
		.write_bytes_s2(write_bytes),
		.line_done_s2(line_done)
	);

	// The input side may only be held off when both pipeline stages are occupied.
	`CBLP_ASSERT_ALWAYS(a_stall_only_full, in_stall |-> (valid_s1_q && valid_s2_q && out_stall), "in_stall raised with a free stage")
	// An accepted command always lands in the first stage.
	`CBLP_ASSERT(a_accept_fills_s1, (in_valid && !in_stall) |=> valid_s1_q, "accepted command lost before the first stage")
	// A first-stage item moves on when the output register is empty.
	`CBLP_ASSERT(a_s1_to_s2, (valid_s1_q && !valid_s2_q) |=> valid_s2_q, "first-stage item did not reach the output register")
	// A pixel that is written lies at non-negative coordinates.
	`CBLP_ASSERT(a_we_on_screen, (out_valid && write_enable) |-> (!pixel_x[15] && !pixel_y[15]), "write enabled for a negative coordinate")

endmodule

### sv/clbp_step.sv
// Bresenham line state and the first pipeline stage holding the emitted pixel.
module clbp_step #(
	parameter int COORD_BITS = clbp_pkg::COORD_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic load,
	input  logic opcode,
	input  logic signed [15:0] start_x,
	input  logic signed [15:0] start_y,
	input  logic signed [15:0] end_x,
	input  logic signed [15:0] end_y,
	input  logic [23:0] color_rgb,
	output logic signed [COORD_BITS-1:0] x_s1,
	output logic signed [COORD_BITS-1:0] y_s1,
	output clbp_pkg::pix_flags_t flags_s1,
	output logic [23:0] color_s1
);
	import clbp_pkg::*;

	localparam int C = COORD_BITS;
	localparam int EW = COORD_BITS + 3;

	typedef logic signed [C-1:0] crd_t;
	typedef logic signed [EW-1:0] err_t;

	crd_t cur_x_q, cur_y_q, tgt_x_q, tgt_y_q;
	logic [C-1:0] abs_dx_q;
	logic signed [C:0] neg_abs_dy_q;
	logic step_x_neg_q, step_y_neg_q, line_active_q;
	err_t error_q;
	logic [23:0] color_q;

	crd_t sx, sy, tx, ty;
	logic signed [C:0] dx, dy;
	logic [C-1:0] adx;
	logic signed [C:0] nady;
	err_t err_start, adx_e, nady_e, err_adv;
	logic signed [EW:0] e2;
	logic mx, my;
	crd_t nx_adv, ny_adv;

	crd_t cur_x_n, cur_y_n, tgt_x_n, tgt_y_n;
	logic [C-1:0] abs_dx_n;
	logic signed [C:0] neg_abs_dy_n;
	logic step_x_neg_n, step_y_neg_n, line_active_n;
	err_t error_n;
	logic [23:0] color_n;
	pix_flags_t flags_n;

	always_comb begin
		sx = crd_t'(start_x);
		sy = crd_t'(start_y);
		tx = crd_t'(end_x);
		ty = crd_t'(end_y);
		dx = (C+1)'(tx) - (C+1)'(sx);
		dy = (C+1)'(ty) - (C+1)'(sy);
		adx = C'(dx[C] ? -dx : dx);
		nady = dy[C] ? dy : -dy;
		err_start = EW'(signed'({1'b0, adx})) + EW'(nady);

		adx_e = EW'(signed'({1'b0, abs_dx_q}));
		nady_e = EW'(neg_abs_dy_q);
		e2 = signed'({error_q, 1'b0});
		mx = e2 >= (EW+1)'(nady_e);
		my = e2 <= (EW+1)'(adx_e);
		err_adv = error_q + (mx ? nady_e : err_t'(0)) + (my ? adx_e : err_t'(0));
		nx_adv = cur_x_q + (mx ? (step_x_neg_q ? crd_t'(-1) : crd_t'(1)) : crd_t'(0));
		ny_adv = cur_y_q + (my ? (step_y_neg_q ? crd_t'(-1) : crd_t'(1)) : crd_t'(0));
	end

	always_comb begin
		cur_x_n = cur_x_q;
		cur_y_n = cur_y_q;
		tgt_x_n = tgt_x_q;
		tgt_y_n = tgt_y_q;
		abs_dx_n = abs_dx_q;
		neg_abs_dy_n = neg_abs_dy_q;
		step_x_neg_n = step_x_neg_q;
		step_y_neg_n = step_y_neg_q;
		error_n = error_q;
		color_n = color_q;
		line_active_n = line_active_q;
		flags_n = '{idle: 1'b1, done: 1'b1};
		if (opcode == OP_START) begin
			cur_x_n = sx;
			cur_y_n = sy;
			tgt_x_n = tx;
			tgt_y_n = ty;
			abs_dx_n = adx;
			neg_abs_dy_n = nady;
			step_x_neg_n = !(sx < tx);
			step_y_neg_n = !(sy < ty);
			error_n = err_start;
			color_n = color_rgb;
			flags_n.idle = 1'b0;
			flags_n.done = (sx == tx) && (sy == ty);
			line_active_n = !flags_n.done;
		end else if (line_active_q) begin
			cur_x_n = nx_adv;
			cur_y_n = ny_adv;
			error_n = err_adv;
			flags_n.idle = 1'b0;
			flags_n.done = (nx_adv == tgt_x_q) && (ny_adv == tgt_y_q);
			line_active_n = !flags_n.done;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q <= '0;
			cur_y_q <= '0;
			tgt_x_q <= '0;
			tgt_y_q <= '0;
			abs_dx_q <= '0;
			neg_abs_dy_q <= '0;
			step_x_neg_q <= 1'b0;
			step_y_neg_q <= 1'b0;
			error_q <= '0;
			color_q <= '0;
			line_active_q <= 1'b0;
		end else if (load) begin
			cur_x_q <= cur_x_n;
			cur_y_q <= cur_y_n;
			tgt_x_q <= tgt_x_n;
			tgt_y_q <= tgt_y_n;
			abs_dx_q <= abs_dx_n;
			neg_abs_dy_q <= neg_abs_dy_n;
			step_x_neg_q <= step_x_neg_n;
			step_y_neg_q <= step_y_neg_n;
			error_q <= error_n;
			color_q <= color_n;
			line_active_q <= line_active_n;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			x_s1 <= cur_x_n;
			y_s1 <= cur_y_n;
			flags_s1 <= flags_n;
			color_s1 <= color_n;
		end
	end

endmodule

### sv/clbp_fmt.sv
// Clipping, byte offset and pixel word formatting into the result register.
module clbp_fmt #(
	parameter int COORD_BITS = clbp_pkg::COORD_BITS_DEF
) (
	input  logic clk,
	input  logic load,
	input  logic signed [COORD_BITS-1:0] x_s1,
	input  logic signed [COORD_BITS-1:0] y_s1,
	input  clbp_pkg::pix_flags_t flags_s1,
	input  logic [23:0] color_s1,
	input  clbp_pkg::cfg_t cfg,
	output logic write_enable_s2,
	output logic signed [15:0] pixel_x_s2,
	output logic signed [15:0] pixel_y_s2,
	output logic [33:0] byte_offset_s2,
	output logic [31:0] pixel_word_s2,
	output logic [2:0] write_bytes_s2,
	output logic line_done_s2
);
	import clbp_pkg::*;

	localparam int UW = (COORD_BITS > 15) ? COORD_BITS : 15;

	logic [UW-1:0] xu, yu;
	logic on;
	logic [14:0] x15, y15;
	logic [32:0] prod;
	logic [16:0] xb;
	logic [33:0] off;
	logic [31:0] word;

	always_comb begin
		xu = UW'($unsigned(x_s1));
		yu = UW'($unsigned(y_s1));
		on = !flags_s1.idle && cfg.buffer_ready &&
			!x_s1[COORD_BITS-1] && !y_s1[COORD_BITS-1] &&
			(xu < UW'(cfg.screen_width)) && (yu < UW'(cfg.screen_height));
		x15 = xu[14:0];
		y15 = yu[14:0];
		prod = 33'(y15) * 33'(cfg.row_pitch_bytes);
		xb = cfg.three_byte_pixels ? (17'({x15, 1'b0}) + 17'(x15)) : {x15, 2'b00};
		off = on ? (34'(prod) + 34'(xb)) : '0;
		if (flags_s1.idle) begin
			word = '0;
		end else if (cfg.bgr_order) begin
			word = {8'h00, color_s1};
		end else begin
			word = {8'h00, color_s1[7:0], color_s1[15:8], color_s1[23:16]};
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			write_enable_s2 <= on;
			pixel_x_s2 <= flags_s1.idle ? 16'sd0 : 16'(x_s1);
			pixel_y_s2 <= flags_s1.idle ? 16'sd0 : 16'(y_s1);
			byte_offset_s2 <= off;
			pixel_word_s2 <= word;
			write_bytes_s2 <= cfg.three_byte_pixels ? BYTES_THREE : BYTES_FOUR;
			line_done_s2 <= flags_s1.done;
		end
	end

endmodule

### dv/tb_clipped_bresenham_line_plotter.sv
`timescale 1ns / 100ps
// Self-checking testbench for the clipped Bresenham line plotter: directed and random commands.
module tb_clipped_bresenham_line_plotter;
	import clbp_pkg::*;

	typedef struct packed {
		op_t op;
		logic [15:0] sx;
		logic [15:0] sy;
		logic [15:0] ex;
		logic [15:0] ey;
		logic [23:0] color;
	} cmd_t;

	typedef struct packed {
		logic we;
		logic [15:0] px;
		logic [15:0] py;
		logic [33:0] off;
		logic [31:0] word;
		logic [2:0] nbytes;
		logic done;
	} pixel_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	op_t opcode = OP_START;
	logic signed [15:0] start_x = '0;
	logic signed [15:0] start_y = '0;
	logic signed [15:0] end_x = '0;
	logic signed [15:0] end_y = '0;
	logic [23:0] color_rgb = '0;
	logic out_valid;
	logic out_stall = 1'b1;
	logic write_enable;
	logic signed [15:0] pixel_x;
	logic signed [15:0] pixel_y;
	logic [33:0] byte_offset;
	logic [31:0] pixel_word;
	logic [2:0] write_bytes;
	logic line_done;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	cfg_reg_t cfg_index = REG_SCREEN_WIDTH;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	clipped_bresenham_line_plotter dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	cmd_t commands_pending[$];
	pixel_t pixel_writes_due[$];
	int cmds_queued = 0;
	int cmds_taken = 0;
	int mismatches = 0;
	bit cmd_taken = 1'b0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	bit hold_request = 1'b0;
	int hold_left = 0;

	cfg_t shadow_cfg = '0;
	logic signed [15:0] ln_x = '0, ln_y = '0, ln_tx = '0, ln_ty = '0;
	int ln_adx = 0, ln_nady = 0, ln_err = 0;
	bit ln_xneg = 1'b0, ln_yneg = 1'b0, ln_active = 1'b0;
	logic [23:0] ln_color = '0;

	function automatic logic [2:0] pixel_size();
		return shadow_cfg.three_byte_pixels ? BYTES_THREE : BYTES_FOUR;
	endfunction

	function automatic pixel_t format_pixel(bit done);
		pixel_t p;
		logic [7:0] r, g, b;
		longint off;
		r = ln_color[23:16];
		g = ln_color[15:8];
		b = ln_color[7:0];
		p.nbytes = pixel_size();
		p.we = shadow_cfg.buffer_ready && ln_x >= 0 && ln_y >= 0 &&
			int'(ln_x) < int'(shadow_cfg.screen_width) &&
			int'(ln_y) < int'(shadow_cfg.screen_height);
		off = 0;
		if (p.we)
			off = longint'(ln_y) * longint'(shadow_cfg.row_pitch_bytes) +
				longint'(ln_x) * longint'(p.nbytes);
		p.off = off[33:0];
		p.px = ln_x;
		p.py = ln_y;
		p.word = shadow_cfg.bgr_order ? {8'h00, r, g, b} : {8'h00, b, g, r};
		p.done = done;
		return p;
	endfunction

	function automatic pixel_t trace_command(cmd_t c);
		pixel_t p;
		int dx, dy, e2;
		bit done;
		if (c.op == OP_START) begin
			ln_x = c.sx;
			ln_y = c.sy;
			ln_tx = c.ex;
			ln_ty = c.ey;
			ln_color = c.color;
			dx = int'(ln_tx) - int'(ln_x);
			dy = int'(ln_ty) - int'(ln_y);
			ln_adx = dx < 0 ? -dx : dx;
			ln_nady = dy < 0 ? dy : -dy;
			ln_xneg = !(ln_x < ln_tx);
			ln_yneg = !(ln_y < ln_ty);
			ln_err = ln_adx + ln_nady;
			done = (ln_x == ln_tx) && (ln_y == ln_ty);
			ln_active = !done;
			return format_pixel(done);
		end
		if (!ln_active) begin
			p = '0;
			p.nbytes = pixel_size();
			p.done = 1'b1;
			return p;
		end
		e2 = ln_err * 2;
		if (e2 >= ln_nady) begin
			ln_err += ln_nady;
			ln_x = ln_xneg ? ln_x - 16'sd1 : ln_x + 16'sd1;
		end
		if (e2 <= ln_adx) begin
			ln_err += ln_adx;
			ln_y = ln_yneg ? ln_y - 16'sd1 : ln_y + 16'sd1;
		end
		done = (ln_x == ln_tx) && (ln_y == ln_ty);
		if (done)
			ln_active = 1'b0;
		return format_pixel(done);
	endfunction

	always @(negedge clk) begin : drive_commands
		cmd_t c;
		if (in_valid && !cmd_taken) begin
		end else if (commands_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
			c = commands_pending.pop_front();
			in_valid <= 1'b1;
			opcode <= c.op;
			start_x <= c.sx;
			start_y <= c.sy;
			end_x <= c.ex;
			end_y <= c.ey;
			color_rgb <= c.color;
		end else begin
			in_valid <= 1'b0;
		end
		cmd_taken = 1'b0;
	end

	always @(negedge clk) begin : drive_stall
		if (hold_request) begin
			hold_left = 120;
			hold_request = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	always @(posedge clk) begin : watch_ports
		pixel_t got, want;
		cmd_t c;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				got = {write_enable, pixel_x, pixel_y, byte_offset, pixel_word,
					write_bytes, line_done};
				if (pixel_writes_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Unexpected pixel write at x=%0d y=%0d.",
							$signed(got.px), $signed(got.py));
				end else begin
					want = pixel_writes_due.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("Pixel write mismatch, expected we=%0d x=%0d y=%0d off=%0h word=%08h bytes=%0d done=%0d",
								want.we, $signed(want.px), $signed(want.py), want.off,
								want.word, want.nbytes, want.done);
							$display("                      actual   we=%0d x=%0d y=%0d off=%0h word=%08h bytes=%0d done=%0d",
								got.we, $signed(got.px), $signed(got.py), got.off,
								got.word, got.nbytes, got.done);
						end
					end
				end
			end
			if (in_valid && !in_stall) begin
				c = {opcode, start_x, start_y, end_x, end_y, color_rgb};
				pixel_writes_due.push_back(trace_command(c));
				cmds_taken++;
				cmd_taken = 1'b1;
			end
		end
	end

	function automatic void push_cmd(op_t op, int sx, int sy, int ex, int ey, int col);
		cmd_t c;
		c.op = op;
		c.sx = sx[15:0];
		c.sy = sy[15:0];
		c.ex = ex[15:0];
		c.ey = ey[15:0];
		c.color = col[23:0];
		commands_pending.push_back(c);
		cmds_queued++;
	endfunction

	function automatic void push_advance();
		push_cmd(OP_ADVANCE, $urandom, $urandom, $urandom, $urandom, $urandom);
	endfunction

	// Mostly complete short lines anywhere on the screen or just off it, some cut short, plus noise.
	function automatic int queue_line_run();
		int pick, sx, sy, dx, dy, steps, adv, n;
		pick = $urandom_range(99);
		if (pick < 75) begin
			sx = int'($urandom_range(int'(shadow_cfg.screen_width) + 16)) - 8;
			sy = int'($urandom_range(int'(shadow_cfg.screen_height) + 16)) - 8;
			dx = int'($urandom_range(48)) - 24;
			dy = int'($urandom_range(48)) - 24;
			steps = (dx < 0 ? -dx : dx) > (dy < 0 ? -dy : dy) ?
				(dx < 0 ? -dx : dx) : (dy < 0 ? -dy : dy);
			if ($urandom_range(99) < 15)
				adv = $urandom_range(steps);
			else
				adv = steps + $urandom_range(2);
			push_cmd(OP_START, sx, sy, sx + dx, sy + dy, $urandom);
		end else if (pick < 90) begin
			adv = $urandom_range(3);
			push_cmd(OP_START, $urandom, $urandom, $urandom, $urandom, $urandom);
		end else begin
			adv = 1 + $urandom_range(2);
			for (n = 0; n < adv; n++)
				push_advance();
			return adv;
		end
		for (n = 0; n < adv; n++)
			push_advance();
		return adv + 1;
	endfunction

	task automatic wait_drained();
		while (cmds_taken != cmds_queued || pixel_writes_due.size() != 0)
			@(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, int value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value[CFG_DATA_W-1:0];
		do
			@(posedge clk);
		while (!cfg_ready);
		case (idx)
			REG_SCREEN_WIDTH: shadow_cfg.screen_width = value[14:0];
			REG_SCREEN_HEIGHT: shadow_cfg.screen_height = value[14:0];
			REG_ROW_PITCH: shadow_cfg.row_pitch_bytes = value[17:0];
			REG_THREE_BYTE: shadow_cfg.three_byte_pixels = value[0];
			REG_BGR_ORDER: shadow_cfg.bgr_order = value[0];
			REG_BUFFER_READY: shadow_cfg.buffer_ready = value[0];
			default: ;
		endcase
	endtask

	task automatic apply_setting(int w, int h, int pitch, int three, int bgr, int ready);
		write_reg(REG_SCREEN_WIDTH, w);
		write_reg(REG_SCREEN_HEIGHT, h);
		write_reg(REG_ROW_PITCH, pitch);
		write_reg(REG_THREE_BYTE, three);
		write_reg(REG_BGR_ORDER, bgr);
		write_reg(REG_BUFFER_READY, ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin : timeout
		#5000000;
		$display("FAIL clipped_bresenham_line_plotter");
		$finish;
	end

	initial begin : run_test
		int phase, count, n;
		send_idle_pct = 34;
		recv_idle_pct = 87;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// With the reset settings no buffer exists, so nothing is written.
		push_advance();
		push_cmd(OP_START, 0, 0, 0, 0, 24'hFFFFFF);
		push_advance();
		wait_drained();

		apply_setting(640, 480, 2560, 0, 0, 1);
		push_cmd(OP_START, -32768, -32768, 32767, 32767, 24'hA5C3E1);
		push_advance();
		push_advance();
		// A new start drops the line still in progress.
		push_cmd(OP_START, 3, 2, -2, 2, 24'h123456);
		for (n = 0; n < 6; n++)
			push_advance();
		push_cmd(OP_START, 639, 479, 641, 475, 24'hFF00FF);
		for (n = 0; n < 4; n++)
			push_advance();
		push_cmd(OP_START, 10, 10, 10, 13, 0);
		for (n = 0; n < 3; n++)
			push_advance();
		push_cmd(OP_START, 32767, -1, 32767, -1, 24'h00FF00);
		wait_drained();

		for (phase = 0; phase < 6; phase++) begin
			case (phase)
				0: apply_setting(16, 12, 48, 1, 1, 1);
				1: apply_setting(32767, 32767, 262143, 0, 1, 1);
				2: apply_setting(1 + $urandom_range(999), 1 + $urandom_range(999),
					$urandom_range(262143), $urandom_range(1), $urandom_range(1), 1);
				3: apply_setting(0, 0, 0, 0, 0, 1);
				4: apply_setting(320, 200, 960, 1, 0, 0);
				default: apply_setting($urandom_range(32767), $urandom_range(32767),
					$urandom_range(262143), $urandom_range(1), $urandom_range(1), 1);
			endcase
			case (phase % 3)
				0: begin
					send_idle_pct = 34;
					recv_idle_pct = 87;
				end
				1: begin
					send_idle_pct = 87;
					recv_idle_pct = 34;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			count = 0;
			while (count < 108)
				count += queue_line_run();
			if (phase == 2) begin
				hold_request = 1'b1;
				wait_drained();
			end
			while (count < 215)
				count += queue_line_run();
			wait_drained();
		end

		repeat (20) @(negedge clk);
		if (pixel_writes_due.size() != 0)
			$display("%0d pixel writes never arrived.", pixel_writes_due.size());
		if (mismatches == 0 && pixel_writes_due.size() == 0)
			$display("PASS clipped_bresenham_line_plotter");
		else
			$display("FAIL clipped_bresenham_line_plotter");
		$finish;
	end

endmodule
